// ===== hw/rtl/fenwick_prefix_sum_table_top_assert.svh =====
// assertion macros shared by the prefix-sum table modules
`ifndef FENWICK_PREFIX_SUM_TABLE_TOP_ASSERT_SVH
`define FENWICK_PREFIX_SUM_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define FPST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FPST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FPST_ASSERT_IMP(lbl, ante, cons, msg)
`define FPST_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/fpst_pkg.sv =====
// shared types and constants for the fenwick prefix-sum table
`timescale 1ns / 1ps
`default_nettype none
package fpst_pkg;
	localparam int unsigned SIZE_DEF = 65536;
	localparam int unsigned REQ_W = 2;
	localparam int unsigned IDX_W = 17;
	localparam int unsigned DATA_W = 32;

	localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WALK,
		ST_CLEAR,
		ST_RESP
	} fpst_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic clr_start;
		logic clr_step;
		logic respond;
	} fpst_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic clr_last;
	} fpst_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/fenwick_prefix_sum_table_top.sv =====
// Fenwick prefix-sum table: SIZE wrapping signed 32-bit counters as a binary indexed tree.
//
// Requests enter by command transfer: req_type, index and delta are taken at a
// rising edge where start is high and busy is low. req_type add walks upward
// from index adding delta, query walks downward summing positions 1..index,
// clear zeroes every counter; other codes do nothing. Every request gives one
// result: prefix_sum with done high for exactly one cycle; it is 0 for all but
// a query. The receiver cannot stall, so nothing waits on it.
// A walk visits the tree nodes on its path and then strobes done; busy falls
// in the cycle where done is high, so the next request may be taken while
// the result is shown. The walk does one read of the single counter memory
// per cycle, with the add writeback overlapped. A clear zeroes one memory
// row per cycle. After reset busy stays high while a sweep zeroes the memory.
// Add at index 0 or beyond SIZE changes nothing; a query beyond SIZE gives the
// total sum.
`timescale 1ns / 1ps
`default_nettype none
module fenwick_prefix_sum_table_top
	import fpst_pkg::*;
#(
	parameter int unsigned SIZE = SIZE_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [REQ_W-1:0]         req_type,
	input  wire logic [IDX_W-1:0]         index,
	input  wire logic signed [DATA_W-1:0] delta,
	output logic                          done,
	output logic signed [DATA_W-1:0]      prefix_sum
);
	fpst_cmd_t  cmd;
	fpst_stat_t stat;

	fpst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	fpst_dp #(
		.SIZE (SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req_type),
		.index      (index),
		.delta      (delta),
		.cmd        (cmd),
		.stat       (stat),
		.done       (done),
		.prefix_sum (prefix_sum)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/fpst_dp.sv =====
// datapath: counter memory, tree walk position, accumulator and result register
`timescale 1ns / 1ps
`default_nettype none
module fpst_dp
	import fpst_pkg::*;
#(
	parameter int unsigned SIZE = SIZE_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [REQ_W-1:0]         req_type,
	input  wire logic [IDX_W-1:0]         index,
	input  wire logic signed [DATA_W-1:0] delta,
	input  wire fpst_cmd_t                cmd,
	output fpst_stat_t                    stat,
	output logic                          done,
	output logic signed [DATA_W-1:0]      prefix_sum
);
`include "fenwick_prefix_sum_table_top_assert.svh"

	localparam int unsigned AW = (SIZE > 1) ? $clog2(SIZE) : 1;
	localparam int unsigned PW = AW + 2;
	localparam int unsigned CW = (PW > IDX_W) ? PW : IDX_W;
	localparam logic [PW-1:0] SIZE_P = PW'(SIZE);
	localparam logic [CW-1:0] SIZE_C = CW'(SIZE);
	localparam logic [AW-1:0] LAST_A = AW'(SIZE - 1);

	logic [DATA_W-1:0] mem [SIZE];

	logic [PW-1:0]     pos_q;
	logic              is_add_q;
	logic              is_query_q;
	logic [DATA_W-1:0] delta_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] rd_data_q;
	logic [AW-1:0]     prev_addr_q;
	logic [DATA_W-1:0] sum_q;
	logic              pend_q;
	logic [AW-1:0]     clr_addr_q;
	logic              done_q;

	logic [CW-1:0]     index_c;
	logic [PW-1:0]     start_pos;
	logic [PW-1:0]     low_bit;
	logic [PW-1:0]     pos_m1;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	// adds beyond the table never enter it, queries beyond it saturate
	always_comb begin
		index_c = CW'(index);
		start_pos = '0;
		if (req_type == REQ_QUERY) begin
			start_pos = (index_c > SIZE_C) ? SIZE_P : PW'(index_c);
		end else if (req_type == REQ_ADD) begin
			start_pos = (index_c > SIZE_C) ? '0 : PW'(index_c);
		end
	end

	assign low_bit = pos_q & (~pos_q + PW'(1));
	assign pos_m1 = pos_q - PW'(1);
	assign rd_addr = pos_m1[AW-1:0];

	assign stat.walk_done = (pos_q == '0) || (pos_q > SIZE_P);
	assign stat.clr_last = (clr_addr_q == LAST_A);

	// add writes back the node read in the previous cycle
	assign wr_en = cmd.clr_step | (pend_q & is_add_q);
	assign wr_addr = cmd.clr_step ? clr_addr_q : prev_addr_q;
	assign wr_data = cmd.clr_step ? '0 : (rd_data_q + delta_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.step) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= start_pos;
			is_add_q <= (req_type == REQ_ADD);
			is_query_q <= (req_type == REQ_QUERY);
			delta_q <= delta;
			acc_q <= '0;
		end else begin
			if (cmd.step) begin
				pos_q <= is_add_q ? (pos_q + low_bit) : (pos_q - low_bit);
				prev_addr_q <= rd_addr;
			end
			if (pend_q && is_query_q) begin
				acc_q <= acc_q + rd_data_q;
			end
		end
		if (cmd.respond) begin
			sum_q <= is_query_q ? acc_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			clr_addr_q <= '0;
			done_q <= 1'b0;
		end else begin
			pend_q <= cmd.step;
			done_q <= cmd.respond;
			if (cmd.clr_start) begin
				clr_addr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	assign done = done_q;
	assign prefix_sum = sum_q;

	`FPST_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe held for two cycles")
	`FPST_ASSERT_IMP(a_wr_exclusive, cmd.clr_step, !pend_q, "clear sweep overlaps a tree walk")
	`FPST_ASSERT_IMP(a_step_in_range, cmd.step, (pos_q != '0) && (pos_q <= SIZE_P),
		"tree walk read outside the table")
endmodule
`default_nettype wire

// ===== hw/rtl/fpst_ctrl.sv =====
// controller state machine: reset sweep, tree walk, clear sweep and response
`timescale 1ns / 1ps
`default_nettype none
module fpst_ctrl
	import fpst_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [REQ_W-1:0] req_type,
	input  wire fpst_stat_t       stat,
	output fpst_cmd_t             cmd,
	output logic                  busy
);
`include "fenwick_prefix_sum_table_top_assert.svh"

	fpst_state_t state_q;
	fpst_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (req_type)
						REQ_ADD, REQ_QUERY: state_d = ST_WALK;
						REQ_CLEAR: state_d = ST_CLEAR;
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_WALK: begin
				if (stat.walk_done) begin
					state_d = ST_RESP;
				end
			end
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_INIT: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				cmd.load = start;
				cmd.clr_start = start && (req_type == REQ_CLEAR);
			end
			ST_WALK: cmd.step = !stat.walk_done;
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_RESP: cmd.respond = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`FPST_ASSERT_NXT(a_accept_leaves_idle, start && !busy, state_q != ST_IDLE,
		"accepted transfer did not start work")
	`FPST_ASSERT_NXT(a_init_once, state_q != ST_INIT, state_q != ST_INIT,
		"reset sweep entered outside reset")
endmodule
`default_nettype wire

// ===== test/tb_fenwick_prefix_sum_table_top.sv =====
// testbench for the fenwick prefix-sum table: directed and random requests checked against a mirror
`timescale 1ns / 1ps
module tb_fenwick_prefix_sum_table_top;
	import fpst_pkg::*;

	localparam int unsigned TABLE_SIZE = SIZE_DEF;
	localparam int unsigned INDEX_MAX = (1 << IDX_W) - 1;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned RANDOM_ITEMS = 1630;
	localparam int unsigned STREAM_ITEMS = 300;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [REQ_W-1:0] req_type;
	logic [IDX_W-1:0] index;
	logic signed [DATA_W-1:0] delta;
	logic done;
	logic signed [DATA_W-1:0] prefix_sum;

	bit [DATA_W-1:0] counter_mirror [TABLE_SIZE];
	logic signed [DATA_W-1:0] pending_sums [$];
	logic signed [DATA_W-1:0] oldest_sum;
	int unsigned fail_count = 0;
	int unsigned clears_left = 3;

	fenwick_prefix_sum_table_top #(
		.SIZE(TABLE_SIZE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.index(index),
		.delta(delta),
		.done(done),
		.prefix_sum(prefix_sum)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("timeout waiting for the table");
		$display("Test completed with failures");
		$finish;
	end

	function automatic void mirror_add_walk(input int unsigned pos, input bit [DATA_W-1:0] amount);
		while (pos != 0 && pos <= TABLE_SIZE) begin
			counter_mirror[pos - 1] += amount;
			pos += pos & (~pos + 1);
		end
	endfunction

	function automatic bit [DATA_W-1:0] mirror_prefix_walk(input int unsigned pos);
		bit [DATA_W-1:0] total;
		total = '0;
		if (pos > TABLE_SIZE)
			pos = TABLE_SIZE;
		while (pos != 0) begin
			total += counter_mirror[pos - 1];
			pos -= pos & (~pos + 1);
		end
		return total;
	endfunction

	function automatic logic signed [DATA_W-1:0] predict_prefix_sum(input logic [REQ_W-1:0] rt,
			input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] dl);
		logic signed [DATA_W-1:0] sum;
		sum = '0;
		case (rt)
			REQ_ADD: mirror_add_walk(32'(idx), dl);
			REQ_QUERY: sum = mirror_prefix_walk(32'(idx));
			REQ_CLEAR: foreach (counter_mirror[i]) counter_mirror[i] = '0;
			default: ;
		endcase
		return sum;
	endfunction

	task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] got,
			input logic signed [DATA_W-1:0] want);
		$display("%0t: %s: prefix_sum %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// each result is shown for exactly one cycle
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_sums.size() == 0) begin
				report_mismatch("result with nothing pending", prefix_sum, '0);
			end else begin
				oldest_sum = pending_sums.pop_front();
				if (prefix_sum !== oldest_sum)
					report_mismatch("wrong sum", prefix_sum, oldest_sum);
			end
		end
	end

	task automatic send_request(input logic [REQ_W-1:0] rt, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] dl);
		logic signed [DATA_W-1:0] want;
		@(negedge clk);
		req_type = rt;
		index = idx;
		delta = dl;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		want = predict_prefix_sum(rt, idx, dl);
		pending_sums = {pending_sums, want};
	endtask

	task automatic idle_gap(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	task automatic wait_drained();
		idle_gap(1);
		while (pending_sums.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return IDX_W'($urandom_range(TABLE_SIZE + 1, INDEX_MAX));
			2: return IDX_W'(TABLE_SIZE);
			3, 4: return IDX_W'(1 << $urandom_range(0, IDX_W - 1));
			5, 6, 7: return IDX_W'($urandom_range(1, 64));
			default: return IDX_W'($urandom_range(1, TABLE_SIZE));
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_delta();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $signed($urandom_range(0, 16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_request();
		int unsigned roll;
		logic [REQ_W-1:0] rt;
		roll = $urandom_range(0, 99);
		if (roll < 46)
			rt = REQ_ADD;
		else if (roll < 92)
			rt = REQ_QUERY;
		else if (roll < 97)
			rt = REQ_UNUSED;
		else if (roll == 99 && clears_left != 0 && $urandom_range(0, 3) == 0) begin
			// a clear sweeps the whole memory, so keep them rare
			rt = REQ_CLEAR;
			clears_left--;
		end else
			rt = REQ_ADD;
		send_request(rt, pick_index(), pick_delta());
	endtask

	task automatic test_index_extremes();
		send_request(REQ_ADD, 1, 5);
		send_request(REQ_ADD, IDX_W'(TABLE_SIZE), -7);
		send_request(REQ_ADD, 0, 100);
		send_request(REQ_ADD, IDX_W'(INDEX_MAX), 11);
		send_request(REQ_ADD, IDX_W'(TABLE_SIZE + 1), 3);
		send_request(REQ_QUERY, 0, 32'sh7fff_ffff);
		send_request(REQ_QUERY, 1, 0);
		send_request(REQ_QUERY, IDX_W'(TABLE_SIZE - 1), 0);
		send_request(REQ_QUERY, IDX_W'(TABLE_SIZE), 0);
		send_request(REQ_QUERY, IDX_W'(INDEX_MAX), -1);
	endtask

	task automatic test_wraparound();
		send_request(REQ_ADD, 2, 32'sh7fff_ffff);
		send_request(REQ_ADD, 3, 32'sh7fff_ffff);
		send_request(REQ_QUERY, 3, 0);
		send_request(REQ_ADD, 4, 32'sh8000_0000);
		send_request(REQ_QUERY, IDX_W'(TABLE_SIZE), 0);
	endtask

	task automatic test_unknown_request();
		send_request(REQ_UNUSED, 5, -1);
		send_request(REQ_QUERY, 5, 0);
	endtask

	task automatic test_clear();
		send_request(REQ_CLEAR, IDX_W'(INDEX_MAX), 32'sh8000_0000);
		send_request(REQ_QUERY, IDX_W'(TABLE_SIZE), 0);
		send_request(REQ_ADD, 8, 1);
		send_request(REQ_QUERY, 8, 0);
	endtask

	// idling switches on and off in stretches of 64 transfers
	task automatic test_random_traffic(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			if ((n / 64) % 2 == 0 && $urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 7));
			send_random_request();
		end
	endtask

	task automatic test_streaming(input int unsigned count);
		repeat (count)
			send_random_request();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_ADD;
		index = '0;
		delta = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_index_extremes();
		test_wraparound();
		test_unknown_request();
		test_clear();
		// hold the next transfer until all results are back
		wait_drained();
		test_random_traffic(RANDOM_ITEMS);
		test_streaming(STREAM_ITEMS);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fpst_pkg.sv
hw/rtl/fpst_dp.sv
hw/rtl/fpst_ctrl.sv
hw/rtl/fenwick_prefix_sum_table_top.sv
test/tb_fenwick_prefix_sum_table_top.sv
